[rtl/pixel_format_color_mapper_macros.svh]
// Assertion macros shared by the pixel format color mapper RTL.
`ifndef PIXEL_FORMAT_COLOR_MAPPER_MACROS_SVH
`define PIXEL_FORMAT_COLOR_MAPPER_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define PFCM_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define PFCM_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pfcm_pkg.sv]
// Types and constants of the pixel format color mapper.
package pfcm_pkg;

  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 32;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int DIST_W    = 18;
  localparam int SHIFT_W   = 5;
  localparam int LOSS_W    = 3;
  localparam int RUN_W     = 4;
  localparam int ENT_W     = 3 * CHAN_W;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_START = DIST_W'((256 * 256) * 3);
  localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'hFF;

  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_MAP    = 2'd1;
  localparam logic [1:0] FN_UNPACK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_COUNT  = 3'd5;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [LOSS_W-1:0]  loss;
  } chan_fmt_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
  } srch_stat_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_CHAN = 6'b000100,
    S_SRCH = 6'b001000,
    S_PRD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

[rtl/pfcm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pfcm_ram #(
  parameter int W  = 24,
  parameter int D  = 256,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/pfcm_scan.sv]
// Bit-serial mask scanner: finds a channel mask's shift and loss.
module pfcm_scan
  import pfcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [PIX_W-1:0] mask,
  output logic             done,
  output chan_fmt_t        fmt
);

  logic               busy_r;
  logic               done_r;
  logic [PIX_W-1:0]   bits_r;
  logic [SHIFT_W-1:0] pos_r;
  logic               found_r;
  logic [SHIFT_W-1:0] spos_r;
  logic [RUN_W-1:0]   run_r;
  chan_fmt_t          fmt_r;

  logic               bit_c;
  logic               found_nxt;
  logic [RUN_W-1:0]   run_nxt;
  logic [SHIFT_W-1:0] spos_nxt;
  logic               finish;
  logic [LOSS_W-1:0]  loss_c;

  always_comb begin
    bit_c     = bits_r[0];
    found_nxt = found_r | bit_c;
    run_nxt   = bit_c ? (found_r ? run_r + RUN_W'(1) : RUN_W'(1)) : run_r;
    spos_nxt  = (bit_c && !found_r) ? pos_r : spos_r;
    finish    = busy_r && ((bits_r == '0) || (found_r && !bit_c) ||
                           (run_nxt == RUN_W'(CHAN_W)));
    if (!found_nxt || (run_nxt >= RUN_W'(CHAN_W))) begin
      loss_c = '0;
    end else begin
      loss_c = LOSS_W'(RUN_W'(CHAN_W) - run_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= finish;
      if (start) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bits_r  <= mask;
      pos_r   <= '0;
      found_r <= 1'b0;
      spos_r  <= '0;
      run_r   <= '0;
    end else if (finish) begin
      fmt_r <= '{shift: spos_nxt, loss: loss_c};
    end else if (busy_r) begin
      bits_r  <= bits_r >> 1;
      pos_r   <= pos_r + SHIFT_W'(1);
      found_r <= found_nxt;
      spos_r  <= spos_nxt;
      run_r   <= run_nxt;
    end
  end

  assign done = done_r;
  assign fmt  = fmt_r;

endmodule

[rtl/pfcm_search.sv]
// Nearest palette entry search: walks entries through a read/square/compare pipe.
module pfcm_search
  import pfcm_pkg::*;
#(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CNT_W-1:0]  n,
  input  logic [CHAN_W-1:0] key_red,
  input  logic [CHAN_W-1:0] key_green,
  input  logic [CHAN_W-1:0] key_blue,
  output logic [AW-1:0]     raddr,
  input  logic [ENT_W-1:0]  ent,
  output srch_stat_t        stat
);

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        ia_r;
  logic                    p1_v_r;
  logic                    p2_v_r;
  logic [AW-1:0]           p1_idx_r;
  logic [AW-1:0]           p2_idx_r;
  logic [2:0][2*CHAN_W-1:0] sq_r;
  logic [DIST_W-1:0]       best_r;
  logic [AW-1:0]           res_r;

  logic                    issue;
  logic [2:0][CHAN_W-1:0]  ad_c;
  logic [DIST_W-1:0]       d_c;
  logic                    better;
  logic                    hit;
  logic                    finish;

  always_comb begin
    issue   = busy_r && (ia_r < n);
    ad_c[0] = (ent[23:16] >= key_red)   ? ent[23:16] - key_red   : key_red - ent[23:16];
    ad_c[1] = (ent[15:8] >= key_green)  ? ent[15:8] - key_green  : key_green - ent[15:8];
    ad_c[2] = (ent[7:0] >= key_blue)    ? ent[7:0] - key_blue    : key_blue - ent[7:0];
    d_c     = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
    better  = busy_r && p2_v_r && (d_c < best_r);
    hit     = better && (d_c == '0);
    finish  = busy_r && (hit || (!issue && !p1_v_r && !p2_v_r));
  end

  assign raddr = ia_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ia_r   <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      done_r <= finish;
      if (start) begin
        busy_r <= 1'b1;
        ia_r   <= '0;
        p1_v_r <= 1'b0;
        p2_v_r <= 1'b0;
      end else begin
        if (finish) begin
          busy_r <= 1'b0;
        end
        if (issue) begin
          ia_r <= ia_r + CNT_W'(1);
        end
        p1_v_r <= issue;
        p2_v_r <= p1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= ia_r[AW-1:0];
    p2_idx_r <= p1_idx_r;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= (2*CHAN_W)'(ad_c[k]) * (2*CHAN_W)'(ad_c[k]);
    end
    if (start) begin
      best_r <= DIST_START;
      res_r  <= '0;
    end else if (better) begin
      best_r <= d_c;
      res_r  <= p2_idx_r;
    end
  end

  assign stat = '{done: done_r, index: IDX_W'(res_r)};

endmodule

[rtl/pixel_format_color_mapper.sv]
// Palette map reads one stored entry per cycle through the palette RAM read port.
// Palette unpack reads the addressed entry and returns it with full alpha (zero colour when out of range).
// Packed map and unpack run the bit-serial mask scanner over the four channels in turn,
//   with a handoff state after each channel's scan.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset: synchronous, active low; masks and mode return to defaults, palette valid flags
//   clear so every entry reads as zero; no clearing pass.
`include "pixel_format_color_mapper_macros.svh"

module pixel_format_color_mapper
  import pfcm_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // entry_index, red_in, green_in, blue_in, alpha_in, pixel_in
  input  logic [IN_W-1:0]      in_tdata,
  // func
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // pixel_out, red_out, green_out, blue_out, alpha_out
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [PIX_W-1:0]         red_mask_r;
  logic [PIX_W-1:0]         green_mask_r;
  logic [PIX_W-1:0]         blue_mask_r;
  logic [PIX_W-1:0]         alpha_mask_r;
  logic                     mode_r;
  logic [CNT_W-1:0]         count_r;

  state_t                   state_r;
  state_t                   state_nxt;
  logic [1:0]               fn_r;
  logic [3:0][CHAN_W-1:0]   key_r;
  logic [PIX_W-1:0]         pix_r;
  logic                     oob_r;
  logic [1:0]               ch_r;
  logic [PIX_W-1:0]         acc_pix_r;
  logic [3:0][CHAN_W-1:0]   col_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;
  logic [PALETTE_DEPTH-1:0] valid_r;
  logic                     vld_q_r;

  logic                     acc;
  logic [1:0]               in_fn;
  logic [CHAN_W-1:0]        in_idx;
  logic [CHAN_W-1:0]        in_red;
  logic [CHAN_W-1:0]        in_grn;
  logic [CHAN_W-1:0]        in_blu;
  logic [CHAN_W-1:0]        in_alp;
  logic [PIX_W-1:0]         in_pix;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            ram_raddr;
  logic [AW-1:0]            srch_raddr;
  logic [ENT_W-1:0]         ram_rdata;
  logic [ENT_W-1:0]         ent_c;
  logic [CNT_W-1:0]         n_c;
  logic                     srch_start;
  srch_stat_t               srch_st;
  logic                     scan_start;
  logic                     scan_done;
  chan_fmt_t                fmt;
  logic [1:0]               scan_ch;
  logic [PIX_W-1:0]         scan_mask;
  logic [PIX_W-1:0]         cur_mask;
  logic [PIX_W-1:0]         pack_c;
  logic [PIX_W-1:0]         ext_c;
  logic [CHAN_W-1:0]        unp_c;
  logic                     load_out;

  function automatic logic [CHAN_W-1:0] chan_rep(logic [CHAN_W-1:0] v,
                                                 logic [LOSS_W-1:0] loss);
    logic [CHAN_W-1:0] r;
    logic [4:0]        s;
    r = v;
    s = 5'd8 - 5'(loss);
    for (int k = 0; k < 3; k++) begin
      if (s < 5'd8) begin
        r = r | (r >> s);
      end
      s = s << 1;
    end
    return r;
  endfunction

  // config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_mask_r   <= 32'h0000_00FF;
      green_mask_r <= 32'h0000_FF00;
      blue_mask_r  <= 32'h00FF_0000;
      alpha_mask_r <= 32'hFF00_0000;
      mode_r       <= 1'b0;
      count_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RED_MASK:   red_mask_r   <= cfg_data;
        CFG_GREEN_MASK: green_mask_r <= cfg_data;
        CFG_BLUE_MASK:  blue_mask_r  <= cfg_data;
        CFG_ALPHA_MASK: alpha_mask_r <= cfg_data;
        CFG_PAL_MODE:   mode_r       <= cfg_data[0];
        CFG_PAL_COUNT:  count_r      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  always_comb begin
    acc    = in_tvalid && in_tready;
    in_fn  = in_tuser;
    in_idx = in_tdata[7:0];
    in_red = in_tdata[15:8];
    in_grn = in_tdata[23:16];
    in_blu = in_tdata[31:24];
    in_alp = in_tdata[39:32];
    in_pix = in_tdata[71:40];
  end

  assign in_tready = (state_r == S_IDLE);
  assign wr_en     = acc && (in_fn == FN_WRITE) &&
                     (CNT_W'(in_idx) < CNT_W'(PALETTE_DEPTH));
  assign wr_addr   = in_idx[AW-1:0];
  assign ram_raddr = (state_r == S_SRCH) ? srch_raddr : in_pix[AW-1:0];
  assign ent_c     = vld_q_r ? ram_rdata : '0;
  assign n_c       = (count_r > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : count_r;
  assign srch_start = acc && (in_fn == FN_MAP) && mode_r;
  assign scan_start = (acc && !mode_r && ((in_fn == FN_MAP) || (in_fn == FN_UNPACK))) ||
                      ((state_r == S_CHAN) && (ch_r != CH_ALPHA));
  assign scan_ch    = (state_r == S_CHAN) ? ch_r + 2'd1 : CH_RED;
  assign load_out   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    case (scan_ch)
      CH_RED:   scan_mask = red_mask_r;
      CH_GREEN: scan_mask = green_mask_r;
      CH_BLUE:  scan_mask = blue_mask_r;
      default:  scan_mask = alpha_mask_r;
    endcase
    case (ch_r)
      CH_RED:   cur_mask = red_mask_r;
      CH_GREEN: cur_mask = green_mask_r;
      CH_BLUE:  cur_mask = blue_mask_r;
      default:  cur_mask = alpha_mask_r;
    endcase
    pack_c = (PIX_W'(key_r[ch_r] >> fmt.loss) << fmt.shift) & cur_mask;
    ext_c  = (pix_r & cur_mask) >> fmt.shift;
    unp_c  = chan_rep(ext_c[CHAN_W-1:0] << fmt.loss, fmt.loss);
    if ((ch_r == CH_ALPHA) && (alpha_mask_r == '0)) begin
      unp_c = FULL_ALPHA;
    end
  end

  pfcm_ram #(
    .W (ENT_W),
    .D (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_red, in_grn, in_blu}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfcm_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .mask  (scan_mask),
    .done  (scan_done),
    .fmt   (fmt)
  );

  pfcm_search #(
    .DEPTH (PALETTE_DEPTH)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (srch_start),
    .n         (n_c),
    .key_red   (key_r[CH_RED]),
    .key_green (key_r[CH_GREEN]),
    .key_blue  (key_r[CH_BLUE]),
    .raddr     (srch_raddr),
    .ent       (ent_c),
    .stat      (srch_st)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_fn == FN_MAP) begin
            state_nxt = mode_r ? S_SRCH : S_SCAN;
          end else if (in_fn == FN_UNPACK) begin
            state_nxt = mode_r ? S_PRD : S_SCAN;
          end
        end
      end
      S_SCAN: if (scan_done) state_nxt = S_CHAN;
      S_CHAN: state_nxt = (ch_r == CH_ALPHA) ? S_DONE : S_SCAN;
      S_SRCH: if (srch_st.done) state_nxt = S_DONE;
      S_PRD:  state_nxt = S_DONE;
      S_DONE: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= CH_RED;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        ch_r <= CH_RED;
      end else if (state_r == S_CHAN) begin
        ch_r <= ch_r + 2'd1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= valid_r[ram_raddr];
    if (acc) begin
      fn_r      <= in_fn;
      key_r     <= {in_alp, in_blu, in_grn, in_red};
      pix_r     <= in_pix;
      oob_r     <= !(CNT_W'(in_pix[7:0]) < CNT_W'(PALETTE_DEPTH));
      acc_pix_r <= '0;
      col_r     <= '0;
    end else if (state_r == S_CHAN) begin
      if (fn_r == FN_MAP) begin
        acc_pix_r <= acc_pix_r | pack_c;
      end else begin
        col_r[ch_r] <= unp_c;
      end
    end else if ((state_r == S_SRCH) && srch_st.done) begin
      acc_pix_r <= PIX_W'(srch_st.index);
    end else if (state_r == S_PRD) begin
      col_r[CH_ALPHA] <= FULL_ALPHA;
      col_r[CH_RED]   <= oob_r ? '0 : ent_c[23:16];
      col_r[CH_GREEN] <= oob_r ? '0 : ent_c[15:8];
      col_r[CH_BLUE]  <= oob_r ? '0 : ent_c[7:0];
    end
    if (load_out) begin
      out_data_r <= {col_r, acc_pix_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PFCM_AST_IMP(a_scan_done_state, scan_done, state_r == S_SCAN, "scan done outside scan")
  `PFCM_AST_IMP(a_srch_done_state, srch_st.done, state_r == S_SRCH, "search done early")
  `PFCM_AST_NXT(a_pal_valid_set, wr_en, valid_r[$past(wr_addr)], "entry not marked valid")
  `PFCM_AST_NXT(a_done_hold, (state_r == S_DONE) && !load_out, state_r == S_DONE, "item lost")

endmodule
